FILE: sv/token_ring_mac_transmitter_defines.svh
// Assertion macros for the token ring MAC transmitter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TOKEN_RING_MAC_TRANSMITTER_DEFINES_SVH
`define TOKEN_RING_MAC_TRANSMITTER_DEFINES_SVH

// same-cycle implication
`define TRMT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRMT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/trmt_pkg.sv
// Shared codes and field widths for the token ring MAC transmitter.
// No dependencies.
package trmt_pkg;

	localparam int CMD_W   = 2;
	localparam int KIND_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 4;
	localparam int SAP_W   = 3;
	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 8;

	// input item kinds
	localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOKEN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BACK    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NEWTOK  = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PHY   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LIST  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOST  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DROP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRUNC = 3'd4;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_OWN_ADDR  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TOKEN_TAG = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONNECTED = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CHAT_BIT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TIME_BIT  = 3'd4;

endpackage

FILE: sv/trmt_if.sv
// Valid/ready channels of the token ring MAC transmitter.
// Depends on trmt_pkg for field widths.
interface trmt_in_if;
	logic                         valid;
	logic                         ready;
	logic [trmt_pkg::CMD_W-1:0]   cmd;
	logic [trmt_pkg::BYTE_W-1:0]  data_byte;
	logic                         last_byte;
	logic [trmt_pkg::ADDR_W-1:0]  dest_address;
	logic [trmt_pkg::SAP_W-1:0]   service_point;

	modport source (output valid, cmd, data_byte, last_byte, dest_address, service_point,
		input ready);
	modport sink (input valid, cmd, data_byte, last_byte, dest_address, service_point,
		output ready);
endinterface

interface trmt_out_if;
	logic                         valid;
	logic                         ready;
	logic [trmt_pkg::KIND_W-1:0]  kind;
	logic [trmt_pkg::BYTE_W-1:0]  value;
	logic                         end_of_run;

	modport source (output valid, kind, value, end_of_run, input ready);
	modport sink (input valid, kind, value, end_of_run, output ready);
endinterface

FILE: sv/trmt_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module trmt_ram #(
	parameter int DEPTH = 144,
	parameter int WIDTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: sv/token_ring_mac_transmitter.sv
// Token ring MAC transmitter: frame builder, token handling, retransmit.
// Depends on trmt_pkg, trmt_if, trmt_ram and the assertion macro header.
//
// Usage:
//  in_ch carries one byte-level item per transfer: a payload byte, a token
//  byte, a returned-frame byte, or a new-token request. out_ch carries the
//  results: bytes for the physical layer plus list-changed, station-lost,
//  dropped and truncated reports; end_of_run flags the last result of an item.
//  Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//  the block does not enforce this. Throughput: a byte ending no message is
//  taken every cycle. A message's last payload byte starts four header/status
//  writes into the frame store. A token's last byte starts a station list
//  scan; token bytes go out one per cycle while the receiver is ready, and
//  a frame from the store or the saved copy goes out a byte at a time, each
//  a registered RAM read, then the output register. The single output
//  register sets the pace of every run; in_ch.ready stays low while a run is
//  being produced. A stalled receiver holds the run where it is, nothing is
//  lost. Reset: asynchronous, clears queue pointers, counters, station list,
//  the saved copy marker and configuration to defaults. Frame store contents
//  are not cleared; no clearing pass is needed.
`include "token_ring_mac_transmitter_defines.svh"

module token_ring_mac_transmitter #(
	parameter int QUEUE_DEPTH   = 4,
	parameter int MAX_PAYLOAD   = 32,
	parameter int STATION_COUNT = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [trmt_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [trmt_pkg::REG_DATA_W-1:0]     cfg_data,
	trmt_in_if.sink                             in_ch,
	trmt_out_if.source                          out_ch
);
	localparam int SLOT_SIZE   = MAX_PAYLOAD + 4;
	localparam int TOKEN_SIZE  = STATION_COUNT + 1;
	localparam int STORE_DEPTH = QUEUE_DEPTH * SLOT_SIZE;
	localparam int SA_W  = $clog2(STORE_DEPTH);
	localparam int SV_W  = $clog2(SLOT_SIZE);
	localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int TK_W  = $clog2(TOKEN_SIZE);
	localparam int TC_W  = $clog2(TOKEN_SIZE + 1);
	localparam int ST_W  = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
	localparam int MAXN  = (SLOT_SIZE > TOKEN_SIZE) ? SLOT_SIZE : TOKEN_SIZE;
	localparam int IDX_W = $clog2(MAXN);
	localparam int BC_W  = 9;   // returned-frame byte counter, covers 3 + 255 and saturates at 511

	typedef enum logic [2:0] {
		ST_IDLE, ST_HDR, ST_SCAN, ST_MSG, ST_SEND_RD, ST_SEND_WT, ST_TOK
	} state_t;

	// configuration
	logic [3:0] own_q;
	logic [7:0] tag_q;
	logic       conn_q;
	logic [2:0] chat_q;
	logic [2:0] time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q  <= '0;
			tag_q  <= 8'hFF;
			conn_q <= 1'b1;
			chat_q <= 3'd1;
			time_q <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trmt_pkg::REG_OWN_ADDR:  own_q  <= cfg_data[3:0];
				trmt_pkg::REG_TOKEN_TAG: tag_q  <= cfg_data;
				trmt_pkg::REG_CONNECTED: conn_q <= cfg_data[0];
				trmt_pkg::REG_CHAT_BIT:  chat_q <= cfg_data[2:0];
				trmt_pkg::REG_TIME_BIT:  time_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   nlast_q;
	logic               src_copy_q;   // frame comes from the store, copied on the fly
	logic               newtok_q;
	logic               changed_q;

	// queue
	logic [QP_W-1:0]    head_q, tail_q;
	logic [QC_W-1:0]    qcount_q;
	logic [LEN_W-1:0]   lens_q [QUEUE_DEPTH];
	logic [SA_W-1:0]    copy_base_q;

	// frame builder
	logic [LEN_W-1:0]   bcount_q;
	logic [7:0]         bsum_q;
	logic               bdrop_q, bover_q;
	logic [7:0]         c0_q, c1_q, stat_q;
	logic [LEN_W-1:0]   flen_q;
	logic               trunc_q;

	// saved copy, token, station list
	logic [LEN_W-1:0]   saved_len_q;
	logic [7:0]         held_q [TOKEN_SIZE];
	logic [TC_W-1:0]    tcount_q;
	logic [7:0]         st_q [STATION_COUNT];

	// returned frame
	logic [BC_W-1:0]    bk_cnt_q;
	logic [3:0]         bk_dest_q;
	logic [7:0]         bk_len_q;
	logic [7:0]         bk_stat_q;

	// result message for single-result steps
	logic [trmt_pkg::KIND_W-1:0] msg_kind_q;
	logic [7:0]         msg_val_q;
	logic               msg_eor_q;
	state_t             msg_next_q;

	// output register
	logic                         ov_q;
	logic [trmt_pkg::KIND_W-1:0]  ok_q;
	logic [7:0]                   oval_q;
	logic                         oeor_q;

	assign out_ch.valid      = ov_q;
	assign out_ch.kind       = ok_q;
	assign out_ch.value      = oval_q;
	assign out_ch.end_of_run = oeor_q;
	assign in_ch.ready       = (state_q == ST_IDLE);

	logic acc, out_free, load_out, end_acc;
	logic [7:0] b;
	assign acc      = in_ch.valid && in_ch.ready;
	assign out_free = !ov_q || out_ch.ready;
	assign b        = in_ch.data_byte;
	// output register takes a new result this cycle
	assign load_out = out_free
		&& (state_q == ST_MSG || state_q == ST_SEND_WT || state_q == ST_TOK);
	assign end_acc  = acc && (in_ch.last_byte || in_ch.cmd == trmt_pkg::CMD_NEWTOK);

	// frame builder step
	logic             p_drop, p_store;
	logic [LEN_W-1:0] p_cnt_n;
	logic [7:0]       p_sum_n, p_c0, p_c1, p_chk;
	logic [SA_W-1:0]  tail_base;

	assign tail_base = SA_W'(tail_q * SLOT_SIZE);
	assign p_drop  = bdrop_q || (bcount_q == '0 && qcount_q >= QC_W'(QUEUE_DEPTH));
	assign p_store = !p_drop && (bcount_q < LEN_W'(MAX_PAYLOAD));
	assign p_cnt_n = p_store ? bcount_q + LEN_W'(1) : bcount_q;
	assign p_sum_n = p_store ? bsum_q + b : bsum_q;
	assign p_c0    = {1'b0, own_q, 3'b000} + 8'(in_ch.service_point);
	assign p_c1    = {1'b0, in_ch.dest_address, 3'b000} + 8'(in_ch.service_point);
	assign p_chk   = p_sum_n + p_c0 + p_c1 + 8'(p_cnt_n);

	// returned-frame field capture
	logic [3:0] bk_dest_n;
	logic [7:0] bk_len_n, bk_stat_n;
	always_comb begin
		bk_dest_n = bk_dest_q;
		bk_len_n  = bk_len_q;
		bk_stat_n = bk_stat_q;
		priority if (bk_cnt_q == BC_W'(1)) begin
			bk_dest_n = b[6:3];
		end else if (bk_cnt_q == BC_W'(2)) begin
			bk_len_n = b;
		end else if (bk_cnt_q >= BC_W'(3) && bk_cnt_q == BC_W'(3) + BC_W'(bk_len_q)) begin
			bk_stat_n = b;
		end
	end

	// token handling
	logic       tok_acc, own_in_tok;
	logic [7:0] svc;
	logic [TK_W-1:0] own_idx;
	assign tok_acc    = acc && in_ch.cmd == trmt_pkg::CMD_TOKEN;
	assign own_in_tok = ({1'b0, own_q} + 5'd1) < 5'(TOKEN_SIZE);
	assign own_idx    = TK_W'({1'b0, own_q} + 5'd1);
	assign svc        = (8'(conn_q) << chat_q) | (8'd1 << time_q);

	// station list scan
	logic [ST_W-1:0] si;
	logic [TK_W-1:0] hi;
	logic            tag_match, sc_diff;
	assign si        = ST_W'(idx_q);
	assign hi        = TK_W'(idx_q) + TK_W'(1);
	assign tag_match = (held_q[0] == tag_q);
	assign sc_diff   = tag_match && (st_q[si] != held_q[hi]);

	// frame store and saved copy
	logic            q_we, s_we, q_re, s_re;
	logic [SA_W-1:0] q_waddr, q_raddr;
	logic [7:0]      q_wdata, q_rdata, s_rdata;
	logic [SV_W-1:0] s_addr;
	logic            hdr_done;

	assign hdr_done = (state_q == ST_HDR) && idx_q == IDX_W'(3);
	assign q_re     = (state_q == ST_SEND_RD) && src_copy_q;
	assign s_re     = (state_q == ST_SEND_RD) && !src_copy_q;
	assign q_raddr  = copy_base_q + SA_W'(idx_q);
	assign s_addr   = SV_W'(idx_q);
	assign s_we     = (state_q == ST_SEND_WT) && out_free && src_copy_q;

	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_base + SA_W'(3) + SA_W'(bcount_q);
		q_wdata = b;
		if (state_q == ST_IDLE && acc && in_ch.cmd == trmt_pkg::CMD_PAYLOAD && p_store) begin
			q_we = 1'b1;
		end else if (state_q == ST_HDR) begin
			q_we = 1'b1;
			unique case (idx_q[1:0])
				2'd0: begin q_waddr = tail_base;            q_wdata = c0_q; end
				2'd1: begin q_waddr = tail_base + SA_W'(1); q_wdata = c1_q; end
				2'd2: begin q_waddr = tail_base + SA_W'(2); q_wdata = 8'(flen_q); end
				2'd3: begin
					q_waddr = tail_base + SA_W'(3) + SA_W'(flen_q);
					q_wdata = stat_q;
				end
			endcase
		end
	end

	trmt_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_store (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.re(q_re), .raddr(q_raddr), .rdata(q_rdata)
	);

	trmt_ram #(.DEPTH(SLOT_SIZE), .WIDTH(8)) u_saved (
		.clk(clk), .we(s_we), .waddr(s_addr), .wdata(q_rdata),
		.re(s_re), .raddr(s_addr), .rdata(s_rdata)
	);

	// held token and slot lengths, no reset needed
	// first token byte clears the rest; own station byte wins on the last byte
	always_ff @(posedge clk) begin
		if (tok_acc) begin
			for (int k = 0; k < TOKEN_SIZE; k++) begin
				if (in_ch.last_byte && own_in_tok && own_idx == TK_W'(k)) begin
					held_q[k] <= svc;
				end else if (tcount_q == '0) begin
					held_q[k] <= (k == 0) ? b : 8'd0;
				end else if (tcount_q < TC_W'(TOKEN_SIZE)
					&& tcount_q[TK_W-1:0] == TK_W'(k)) begin
					held_q[k] <= b;
				end
			end
		end
		if (hdr_done) begin
			lens_q[tail_q] <= flen_q;
		end
	end

	logic [7:0] tok_byte, rd_byte;
	assign tok_byte = newtok_q ? ((idx_q == '0) ? tag_q : 8'd0) : held_q[TK_W'(idx_q)];
	assign rd_byte  = src_copy_q ? q_rdata : s_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		state_t nxt;
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			nlast_q     <= '0;
			src_copy_q  <= 1'b0;
			newtok_q    <= 1'b0;
			changed_q   <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			qcount_q    <= '0;
			copy_base_q <= '0;
			bcount_q    <= '0;
			bsum_q      <= '0;
			bdrop_q     <= 1'b0;
			bover_q     <= 1'b0;
			c0_q        <= '0;
			c1_q        <= '0;
			stat_q      <= '0;
			flen_q      <= '0;
			trunc_q     <= 1'b0;
			saved_len_q <= '0;
			tcount_q    <= '0;
			for (int k = 0; k < STATION_COUNT; k++) begin
				st_q[k] <= '0;
			end
			bk_cnt_q    <= '0;
			bk_dest_q   <= '0;
			bk_len_q    <= '0;
			bk_stat_q   <= '0;
			msg_kind_q  <= trmt_pkg::KIND_PHY;
			msg_val_q   <= '0;
			msg_eor_q   <= 1'b0;
			msg_next_q  <= ST_IDLE;
			ov_q        <= 1'b0;
			ok_q        <= trmt_pkg::KIND_PHY;
			oval_q      <= '0;
			oeor_q      <= 1'b0;
		end else begin
			nxt = ST_TOK;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (in_ch.cmd)
							trmt_pkg::CMD_PAYLOAD: begin
								if (in_ch.last_byte) begin
									bcount_q <= '0;
									bsum_q   <= '0;
									bdrop_q  <= 1'b0;
									bover_q  <= 1'b0;
									if (p_drop) begin
										msg_kind_q <= trmt_pkg::KIND_DROP;
										msg_val_q  <= '0;
										msg_eor_q  <= 1'b1;
										msg_next_q <= ST_IDLE;
										state_q    <= ST_MSG;
									end else begin
										c0_q    <= p_c0;
										c1_q    <= p_c1;
										flen_q  <= p_cnt_n;
										stat_q  <= {p_chk[5:0], 2'b00};
										trunc_q <= bover_q || !p_store;
										idx_q   <= '0;
										state_q <= ST_HDR;
									end
								end else begin
									bcount_q <= p_cnt_n;
									bsum_q   <= p_sum_n;
									bdrop_q  <= p_drop;
									bover_q  <= bover_q || (!p_drop && !p_store);
								end
							end
							trmt_pkg::CMD_TOKEN: begin
								if (in_ch.last_byte) begin
									tcount_q  <= '0;
									idx_q     <= '0;
									changed_q <= 1'b0;
									state_q   <= ST_SCAN;
								end else if (tcount_q < TC_W'(TOKEN_SIZE)) begin
									tcount_q <= tcount_q + TC_W'(1);
								end
							end
							trmt_pkg::CMD_BACK: begin
								if (in_ch.last_byte) begin
									bk_cnt_q  <= '0;
									bk_dest_q <= '0;
									bk_len_q  <= '0;
									bk_stat_q <= '0;
									idx_q     <= '0;
									newtok_q  <= 1'b0;
									priority if (bk_stat_n[1] && bk_stat_n[0]) begin
										// acknowledged: release the token
										saved_len_q <= '0;
										state_q     <= ST_TOK;
									end else if (bk_stat_n[1]) begin
										// read but not acked: resend the copy if any
										if (saved_len_q != '0) begin
											src_copy_q <= 1'b0;
											nlast_q    <= IDX_W'(saved_len_q) + IDX_W'(3);
											state_q    <= ST_SEND_RD;
										end else begin
											state_q <= ST_TOK;
										end
									end else begin
										// not read: station lost
										saved_len_q <= '0;
										msg_kind_q  <= trmt_pkg::KIND_LOST;
										msg_val_q   <= 8'(bk_dest_n) + 8'd1;
										msg_eor_q   <= 1'b0;
										msg_next_q  <= ST_TOK;
										state_q     <= ST_MSG;
									end
								end else begin
									bk_dest_q <= bk_dest_n;
									bk_len_q  <= bk_len_n;
									bk_stat_q <= bk_stat_n;
									if (bk_cnt_q != '1) begin
										bk_cnt_q <= bk_cnt_q + BC_W'(1);
									end
								end
							end
							trmt_pkg::CMD_NEWTOK: begin
								newtok_q <= 1'b1;
								idx_q    <= '0;
								state_q  <= ST_TOK;
							end
						endcase
					end
				end
				ST_HDR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (hdr_done) begin
						tail_q   <= (tail_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QP_W'(1);
						qcount_q <= qcount_q + QC_W'(1);
						if (trunc_q) begin
							msg_kind_q <= trmt_pkg::KIND_TRUNC;
							msg_val_q  <= '0;
							msg_eor_q  <= 1'b1;
							msg_next_q <= ST_IDLE;
							state_q    <= ST_MSG;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (sc_diff) begin
						st_q[si]  <= held_q[hi];
						changed_q <= 1'b1;
					end
					if (idx_q == IDX_W'(STATION_COUNT - 1)) begin
						idx_q    <= '0;
						newtok_q <= 1'b0;
						if (qcount_q != '0) begin
							// oldest frame goes out and becomes the saved copy
							saved_len_q <= lens_q[head_q];
							nlast_q     <= IDX_W'(lens_q[head_q]) + IDX_W'(3);
							copy_base_q <= SA_W'(head_q * SLOT_SIZE);
							head_q      <= (head_q == QP_W'(QUEUE_DEPTH - 1)) ? '0
								: head_q + QP_W'(1);
							qcount_q    <= qcount_q - QC_W'(1);
							src_copy_q  <= 1'b1;
							nxt = ST_SEND_RD;
						end
						if (changed_q || sc_diff) begin
							msg_kind_q <= trmt_pkg::KIND_LIST;
							msg_val_q  <= '0;
							msg_eor_q  <= 1'b0;
							msg_next_q <= nxt;
							state_q    <= ST_MSG;
						end else begin
							state_q <= nxt;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_MSG: begin
					if (out_free) begin
						ok_q    <= msg_kind_q;
						oval_q  <= msg_val_q;
						oeor_q  <= msg_eor_q;
						state_q <= msg_next_q;
					end
				end
				ST_SEND_RD: begin
					state_q <= ST_SEND_WT;
				end
				ST_SEND_WT: begin
					if (out_free) begin
						ok_q   <= trmt_pkg::KIND_PHY;
						oval_q <= rd_byte;
						oeor_q <= (idx_q == nlast_q);
						if (idx_q == nlast_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_SEND_RD;
						end
					end
				end
				ST_TOK: begin
					if (out_free) begin
						ok_q   <= trmt_pkg::KIND_PHY;
						oval_q <= tok_byte;
						oeor_q <= (idx_q == IDX_W'(TOKEN_SIZE - 1));
						if (idx_q == IDX_W'(TOKEN_SIZE - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
			endcase
		end
	end

	// queue occupancy never passes the slot count
	`TRMT_ASSERT_IMP(a_qcount_bound, 1'b1, qcount_q <= QC_W'(QUEUE_DEPTH), "queue overfilled")
	// an item that ends a message or token always starts a busy run
	`TRMT_ASSERT_NXT(a_busy_after_end, end_acc, !in_ch.ready, "not busy after end")
	// saved copy length stays within the payload limit
	`TRMT_ASSERT_IMP(a_saved_len, 1'b1, saved_len_q <= LEN_W'(MAX_PAYLOAD), "saved length too long")

endmodule
